FILE: rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the stuffed frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int PAYLOAD_BYTES_DEF = 4;
  localparam int WORD_BYTES        = 4;

  localparam logic [7:0] SUB_START      = 8'h06;
  localparam logic [7:0] SUB_END        = 8'h05;
  localparam logic [7:0] CHECKSUM_VALUE = 8'h00;

  localparam logic [7:0] START_RESET  = 8'd2;
  localparam logic [7:0] END_RESET    = 8'd3;
  localparam logic [7:0] ESCAPE_RESET = 8'd16;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  // One stuffed payload byte: first byte, optional second byte.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } lane_t;

endpackage

FILE: rtl/sfe_lane.sv
// ----------------------------------------------------------------------------
// sfe_lane
// Stuffs one payload byte against the start, end and escape markers.
// ----------------------------------------------------------------------------
module sfe_lane (
  input  logic [7:0]    data_byte,
  input  sfe_pkg::cfg_t cfg,
  output sfe_pkg::lane_t result
);

  // Priority: start, then end, then escape.
  always_comb begin
    result.two = 1'b1;
    result.b0  = cfg.escape_byte;
    result.b1  = cfg.escape_byte;
    if (data_byte == cfg.start_byte) begin
      result.b1 = sfe_pkg::SUB_START;
    end else if (data_byte == cfg.end_byte) begin
      result.b1 = sfe_pkg::SUB_END;
    end else if (data_byte == cfg.escape_byte) begin
      result.b1 = cfg.escape_byte;
    end else begin
      result.two = 1'b0;
      result.b0  = data_byte;
    end
  end

endmodule

FILE: rtl/sfe_merge.sv
// ----------------------------------------------------------------------------
// sfe_merge
// Merges the lane results into one frame and sends it a byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sfe_merge #(
  parameter int PAYLOAD_BYTES = sfe_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sfe_pkg::cfg_t                          cfg,
  input  logic                                   pend_valid,
  input  sfe_pkg::lane_t [PAYLOAD_BYTES-1:0]     pend_lanes,
  output logic                                   take,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [7:0]                             out_byte,
  output logic                                   last_byte
);

  localparam int LANE_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int LEN_W  = $clog2(2 * PAYLOAD_BYTES + 1);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(PAYLOAD_BYTES - 1);
  localparam logic [7:0] TYPE_BYTE = 8'(PAYLOAD_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_TYPE  = 7'b0000100,
    S_LEN   = 7'b0001000,
    S_DATA  = 7'b0010000,
    S_CSUM  = 7'b0100000,
    S_END   = 7'b1000000
  } state_t;

  state_t                             state, state_next;
  sfe_pkg::lane_t [PAYLOAD_BYTES-1:0] lanes;
  logic [LEN_W-1:0]                   len;
  logic [LEN_W-1:0]                   len_next;
  logic [LANE_W-1:0]                  lane_sel;
  logic                               sub_sel;
  logic                               advance;
  sfe_pkg::lane_t                     cur;

  assign advance = !out_valid || out_ready;
  assign take    = pend_valid && ((state == S_IDLE) || ((state == S_END) && advance));
  assign cur     = lanes[lane_sel];

  always_comb begin
    len_next = '0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      len_next = len_next + LEN_W'(1) + LEN_W'(pend_lanes[k].two);
    end
  end

  always_comb begin
    state_next = state;
    if (advance) begin
      case (state)
        S_IDLE:  state_next = S_IDLE;
        S_START: state_next = S_TYPE;
        S_TYPE:  state_next = S_LEN;
        S_LEN:   state_next = S_DATA;
        S_DATA: begin
          if ((sub_sel || !cur.two) && (lane_sel == LANE_LAST)) state_next = S_CSUM;
        end
        S_CSUM:  state_next = S_END;
        S_END:   state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
    if (take) state_next = S_START;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= (state != S_IDLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lanes    <= pend_lanes;
      len      <= len_next;
      lane_sel <= '0;
      sub_sel  <= 1'b0;
    end else if (advance && (state == S_DATA)) begin
      // walk the second byte of an escaped lane before moving on
      if (!sub_sel && cur.two) begin
        sub_sel <= 1'b1;
      end else begin
        sub_sel <= 1'b0;
        if (lane_sel != LANE_LAST) lane_sel <= lane_sel + LANE_W'(1);
      end
    end
    if (advance) begin
      last_byte <= (state == S_END);
      case (state)
        S_START: out_byte <= cfg.start_byte;
        S_TYPE:  out_byte <= TYPE_BYTE;
        S_LEN:   out_byte <= 8'(len);
        S_DATA:  out_byte <= sub_sel ? cur.b1 : cur.b0;
        S_CSUM:  out_byte <= sfe_pkg::CHECKSUM_VALUE;
        S_END:   out_byte <= cfg.end_byte;
        default: out_byte <= out_byte;
      endcase
    end
  end

endmodule

FILE: rtl/stuffed_frame_encoder.sv
// ----------------------------------------------------------------------------
// stuffed_frame_encoder
// Byte-stuffing frame encoder: one payload word in, one framed byte stream out.
// ----------------------------------------------------------------------------
// An accepted word passes the holding register, the frame state register and
// the output byte register. Throughput: one byte per cycle while out_ready is
// high; a frame is 5 + stuffed length bytes (9 to 13 with four payload bytes).
// One word waits in a holding register while the previous frame drains.
// Reset (synchronous) empties the pipeline and restores the marker registers.
module stuffed_frame_encoder #(
  parameter int PAYLOAD_BYTES = sfe_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] payload_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  sfe_pkg::cfg_t                      cfg;
  sfe_pkg::lane_t [PAYLOAD_BYTES-1:0] lane_res;
  sfe_pkg::lane_t [PAYLOAD_BYTES-1:0] pend_lanes;
  logic                               pend_valid;
  logic                               take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= sfe_pkg::START_RESET;
      cfg.end_byte    <= sfe_pkg::END_RESET;
      cfg.escape_byte <= sfe_pkg::ESCAPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sfe_pkg::REG_START:  cfg.start_byte  <= cfg_data;
        sfe_pkg::REG_END:    cfg.end_byte    <= cfg_data;
        sfe_pkg::REG_ESCAPE: cfg.escape_byte <= cfg_data;
        default:             cfg             <= cfg;
      endcase
    end
  end

  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_lane
    logic [7:0] data_byte;
    if (k < sfe_pkg::WORD_BYTES) begin : g_word
      assign data_byte = payload_word[8*k +: 8];
    end else begin : g_zero
      assign data_byte = 8'h00;
    end
    sfe_lane u_lane (
      .data_byte (data_byte),
      .cfg       (cfg),
      .result    (lane_res[k])
    );
  end

  assign in_ready = !pend_valid || take;

  // hold one stuffed word while the current frame drains
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pend_lanes <= lane_res;
  end

  sfe_merge #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pend_valid (pend_valid),
    .pend_lanes (pend_lanes),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

endmodule

FILE: sim/stuffed_frame_encoder_test.sv
// ----------------------------------------------------------------------------
// stuffed_frame_encoder_test
// Self-checking bench for the stuffed frame encoder. A directed table covers
// marker extremes, stuffing of every marker, colliding marker registers and
// the unused register index. A random part follows, with marker settings
// changed between phases. A local frame builder predicts each frame not typed in the table.
// ----------------------------------------------------------------------------
module stuffed_frame_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         PB              = sfe_pkg::PAYLOAD_BYTES_DEF;
  localparam logic [1:0] REG_UNUSED      = 2'd3;
  localparam int         CYCLE_LIMIT     = 250000;
  localparam int         RANDOM_WORDS    = 105;
  localparam int         HOLD_OFF_AT     = 400;
  localparam int         HOLD_OFF_CYCLES = 200;

  typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   idx;
    logic [31:0]  value;
    logic [3:0]   lit_len;  // 0: use the frame builder
    logic [103:0] lit;      // typed frame, first byte most significant
  } dir_row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  localparam dir_row_t DIR_ROWS [24] = '{
    '{ROW_WORD, sfe_pkg::REG_START,  32'h0000_0000, 4'd9,
      104'h02_04_04_00_00_00_00_00_03},
    '{ROW_WORD, sfe_pkg::REG_START,  32'hFFFF_FFFF, 4'd9,
      104'h02_04_04_FF_FF_FF_FF_00_03},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h1003_0201, 4'd12,
      104'h02_04_07_01_10_06_10_05_10_10_00_03},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h0202_0202, 4'd13,
      104'h02_04_08_10_06_10_06_10_06_10_06_00_03},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h1010_1010, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h0303_0303, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'hA5A5_5A5A, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h5AA5_0000, 4'd0,  104'h0},
    '{ROW_CFG,  sfe_pkg::REG_START,  32'h0000_0000, 4'd0,  104'h0},
    '{ROW_CFG,  sfe_pkg::REG_END,    32'h0000_00FF, 4'd0,  104'h0},
    '{ROW_CFG,  sfe_pkg::REG_ESCAPE, 32'h0000_0080, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h0000_0000, 4'd13,
      104'h00_04_08_80_06_80_06_80_06_80_06_00_FF},
    '{ROW_WORD, sfe_pkg::REG_START,  32'hFF80_FF00, 4'd0,  104'h0},
    '{ROW_CFG,  REG_UNUSED,          32'h0000_0055, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h5555_5555, 4'd0,  104'h0},
    // start and end equal: start wins
    '{ROW_CFG,  sfe_pkg::REG_END,    32'h0000_0000, 4'd0,  104'h0},
    '{ROW_CFG,  sfe_pkg::REG_ESCAPE, 32'h0000_0000, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h00FF_0080, 4'd0,  104'h0},
    // end and escape equal: end wins
    '{ROW_CFG,  sfe_pkg::REG_START,  32'h0000_00FF, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h0000_00FF, 4'd0,  104'h0},
    '{ROW_CFG,  sfe_pkg::REG_END,    32'h0000_007E, 4'd0,  104'h0},
    '{ROW_CFG,  sfe_pkg::REG_ESCAPE, 32'h0000_007E, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h7E7E_0000, 4'd0,  104'h0},
    '{ROW_WORD, sfe_pkg::REG_START,  32'h1234_5678, 4'd0,  104'h0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] payload_word;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        last_byte;

  logic [7:0]  mark_start;
  logic [7:0]  mark_end;
  logic [7:0]  mark_escape;

  frame_byte_t frame_due [$];
  int          errors;
  int          bytes_seen;
  int          cycle_count;

  stuffed_frame_encoder #(.PAYLOAD_BYTES(PB)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_word (payload_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build the stuffed frame for one word and queue its bytes.
  function automatic void stuff_frame(input logic [31:0] word);
    logic [7:0] body [2*PB];
    logic [7:0] b;
    int         len;
    len = 0;
    for (int k = 0; k < PB; k++) begin
      b = (k < sfe_pkg::WORD_BYTES) ? word[8*k +: 8] : 8'h00;
      if (b == mark_start) begin
        body[len]   = mark_escape;
        body[len+1] = sfe_pkg::SUB_START;
        len += 2;
      end else if (b == mark_end) begin
        body[len]   = mark_escape;
        body[len+1] = sfe_pkg::SUB_END;
        len += 2;
      end else if (b == mark_escape) begin
        body[len]   = mark_escape;
        body[len+1] = mark_escape;
        len += 2;
      end else begin
        body[len] = b;
        len += 1;
      end
    end
    frame_due.push_back('{mark_start, 1'b0});
    frame_due.push_back('{8'(PB), 1'b0});
    frame_due.push_back('{8'(len), 1'b0});
    for (int k = 0; k < len; k++) frame_due.push_back('{body[k], 1'b0});
    frame_due.push_back('{sfe_pkg::CHECKSUM_VALUE, 1'b0});
    frame_due.push_back('{mark_end, 1'b1});
  endfunction

  // Mostly back to back, sometimes short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return mark_start;
      3:       return mark_escape;
      default: return 8'($urandom);
    endcase
  endfunction

  // Bias payload bytes toward the current markers so stuffing is common.
  function automatic logic [31:0] pick_payload();
    logic [31:0] w;
    if ($urandom_range(0, 7) == 0) return $urandom;
    for (int k = 0; k < sfe_pkg::WORD_BYTES; k++) begin
      case ($urandom_range(0, 9))
        0, 1:    w[8*k +: 8] = mark_start;
        2:       w[8*k +: 8] = mark_end;
        3:       w[8*k +: 8] = mark_escape;
        default: w[8*k +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      sfe_pkg::REG_START:  mark_start  = data;
      sfe_pkg::REG_END:    mark_end    = data;
      sfe_pkg::REG_ESCAPE: mark_escape = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_word(input logic [31:0] word, input bit predict);
    @(negedge clk);
    in_valid     = 1'b1;
    payload_word = word;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (predict) stuff_frame(word);
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_valid     = 1'b0;
    payload_word = $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_frames();
    idle_input(1);
    while (frame_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Output checker
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && out_valid && out_ready) begin
      bytes_seen++;
      if (frame_due.size() == 0) begin
        report_mismatch("byte with no frame pending", out_byte, 8'h00);
      end else begin
        want = frame_due.pop_front();
        if (out_byte !== want.value) report_mismatch("out_byte", out_byte, want.value);
        if (last_byte !== want.last)
          report_mismatch("last_byte", 8'(last_byte), 8'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, steady stretches, one long hold-off.
  initial begin
    int  stall;
    int  mode_left;
    bit  steady;
    bit  held;
    out_ready = 1'b0;
    stall     = 0;
    mode_left = 0;
    steady    = 1'b0;
    held      = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 150);
      end
      mode_left--;
      if (!held && bytes_seen >= HOLD_OFF_AT) begin
        // hold off long enough for the encoder to back up into its input
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    int  gap;
    int  sent;
    int  phase_words;
    bit  burst;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = sfe_pkg::REG_START;
    cfg_data     = 8'h00;
    in_valid     = 1'b0;
    payload_word = 32'h0;
    mark_start   = sfe_pkg::START_RESET;
    mark_end     = sfe_pkg::END_RESET;
    mark_escape  = sfe_pkg::ESCAPE_RESET;
    errors       = 0;
    bytes_seen   = 0;
    cycle_count  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        drain_frames();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value[7:0]);
      end else begin
        send_word(DIR_ROWS[i].value, DIR_ROWS[i].lit_len == 0);
        for (int j = int'(DIR_ROWS[i].lit_len) - 1; j >= 0; j--)
          frame_due.push_back('{DIR_ROWS[i].lit[8*j +: 8], j == 0});
        gap = pick_gap();
        if (gap > 0) idle_input(gap);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      drain_frames();
      write_reg(sfe_pkg::REG_START, pick_marker());
      write_reg(sfe_pkg::REG_END, pick_marker());
      write_reg(sfe_pkg::REG_ESCAPE, pick_marker());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 8'($urandom));
      burst       = ($urandom_range(0, 2) == 0);
      phase_words = $urandom_range(15, 35);
      repeat (phase_words) begin
        if (sent >= RANDOM_WORDS) break;
        send_word(pick_payload(), 1'b1);
        sent++;
        if (!burst) begin
          gap = pick_gap();
          if (gap > 0) idle_input(gap);
        end
      end
    end

    drain_frames();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sfe_pkg.sv
rtl/sfe_lane.sv
rtl/sfe_merge.sv
rtl/stuffed_frame_encoder.sv
sim/stuffed_frame_encoder_test.sv
